@@ hw/rtl/haar2d_pkg.sv @@
// Shared constants, types and helpers of the one-level 2D Haar transform.
package haar2d_pkg;

  // Line store and frame size limits
  localparam int MaxWidth    = 2048;
  localparam int HeightLimit = 2048;

  // Field widths
  localparam int PixW  = 8;
  localparam int CoefW = 11;
  localparam int BandW = 2;
  localparam int PosW  = 10;
  localparam int DimW  = 12;
  localparam int CntW  = $clog2(MaxWidth);
  localparam int PairW = 2 * PixW;
  localparam int PairDepth = MaxWidth / 2;

  // Configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Register indexes (paddr bit 2)
  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_t;

  // Subband codes
  typedef enum logic [BandW-1:0] {
    BandLL = 2'd0,
    BandH  = 2'd1,
    BandV  = 2'd2,
    BandD  = 2'd3
  } subband_t;

  // Frame geometry handed from the register block to the datapath
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            restart;
  } cfg_t;

  // Limit a frame dimension to the range [2, hi]
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimW'(2)) begin
      r = DimW'(2);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/haar2d_if.sv @@
// Stream interfaces: pixel input and coefficient output.
interface haar2d_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [haar2d_pkg::PixW-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface haar2d_coef_if;
  logic                                valid;
  logic                                ready;
  logic signed [haar2d_pkg::CoefW-1:0] coefficient;
  logic [haar2d_pkg::BandW-1:0]        subband;
  logic [haar2d_pkg::PosW-1:0]         band_row;
  logic [haar2d_pkg::PosW-1:0]         band_col;
  logic                                last_of_block;

  modport source (output valid, output coefficient, output subband, output band_row,
                  output band_col, output last_of_block, input ready);
  modport sink   (input valid, input coefficient, input subband, input band_row,
                  input band_col, input last_of_block, output ready);
endinterface

@@ hw/rtl/haar_2d_one_level_transform_top.sv @@
// The pixels of a completing block pass into the block register; the LL result is computed from
// them into the output register, and the other three results follow it in the order H, V, D.
// Throughput: one pixel per cycle on even rows; on odd rows the pixel that completes a block
// waits until the previous block has loaded all four of its results for the single coefficient port.
// Reset clears counters and valid flags and loads width 640, height 480; the line
// store is not cleared.
module haar_2d_one_level_transform_top (
  input  logic                          clk,
  input  logic                          rst,
  haar2d_pixel_if.sink                  pixels,
  haar2d_coef_if.source                 coefs,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [haar2d_pkg::AddrW-1:0]  paddr,
  input  logic [haar2d_pkg::DataW-1:0]  pwdata,
  output logic [haar2d_pkg::DataW-1:0]  prdata,
  output logic                          pready
);

  localparam int CntW  = haar2d_pkg::CntW;
  localparam int DimW  = haar2d_pkg::DimW;
  localparam int PixW  = haar2d_pkg::PixW;
  localparam int CoefW = haar2d_pkg::CoefW;
  localparam int PosW  = haar2d_pkg::PosW;

  haar2d_pkg::cfg_t cfg;

  haar2d_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Raster position
  logic [CntW-1:0] col;
  logic [CntW-1:0] row;
  logic [DimW-1:0] col_inc;
  logic [DimW-1:0] row_inc;

  // Line store holds even-row pixels as left/right pairs
  logic [haar2d_pkg::PairW-1:0] pair_mem [haar2d_pkg::PairDepth];
  logic [haar2d_pkg::PairW-1:0] rd_pair;
  logic [PixW-1:0]              held;

  // Block register: the four pixels of one block and the result sequence
  logic                 blk_valid;
  haar2d_pkg::subband_t blk_phase;
  logic [PixW-1:0]      blk_a, blk_b, blk_c, blk_d;
  logic [PosW-1:0]      blk_row, blk_col;

  // Output register
  logic                 out_valid;
  logic signed [CoefW-1:0] out_coef;
  haar2d_pkg::subband_t out_band;
  logic [PosW-1:0]      out_row, out_col;
  logic                 out_last;

  logic in_acc, block_now, out_load, blk_free;
  logic signed [CoefW-1:0] a_s, b_s, c_s, d_s, ab_sum, ab_dif, cd_sum, cd_dif, coef_sel;

  // Handshake
  assign block_now = row[0] & col[0];
  assign out_load  = blk_valid & (~out_valid | coefs.ready);
  assign blk_free  = ~blk_valid | (out_load & (blk_phase == haar2d_pkg::BandD));
  assign pixels.ready = ~block_now | blk_free;
  assign in_acc    = pixels.valid & pixels.ready;

  // Counter increments
  assign col_inc = DimW'(col) + DimW'(1);
  assign row_inc = DimW'(row) + DimW'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col_inc >= cfg.width) begin
        col <= '0;
        row <= (row_inc >= cfg.height) ? '0 : row_inc[CntW-1:0];
      end else begin
        col <= col_inc[CntW-1:0];
      end
    end
  end

  // Line store write, pair read and held left pixel
  always_ff @(posedge clk) begin
    if (in_acc && !row[0] && col[0]) begin
      pair_mem[col[CntW-1:1]] <= {pixels.pixel, held};
    end
    if (in_acc && row[0] && !col[0]) begin
      rd_pair <= pair_mem[col[CntW-1:1]];
    end
    if (in_acc && !col[0]) begin
      held <= pixels.pixel;
    end
  end

  // Block capture and result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      blk_phase <= haar2d_pkg::BandLL;
    end else if (in_acc && block_now) begin
      blk_valid <= 1'b1;
      blk_phase <= haar2d_pkg::BandLL;
    end else if (out_load) begin
      if (blk_phase == haar2d_pkg::BandD) begin
        blk_valid <= 1'b0;
      end
      blk_phase <= haar2d_pkg::subband_t'(blk_phase + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && block_now) begin
      blk_a   <= rd_pair[PixW-1:0];
      blk_b   <= rd_pair[2*PixW-1:PixW];
      blk_c   <= held;
      blk_d   <= pixels.pixel;
      blk_row <= row[CntW-1:1];
      blk_col <= col[CntW-1:1];
    end
  end

  // Butterfly: shared sums and differences, then one per subband
  assign a_s    = CoefW'(signed'({1'b0, blk_a}));
  assign b_s    = CoefW'(signed'({1'b0, blk_b}));
  assign c_s    = CoefW'(signed'({1'b0, blk_c}));
  assign d_s    = CoefW'(signed'({1'b0, blk_d}));
  assign ab_sum = a_s + b_s;
  assign ab_dif = a_s - b_s;
  assign cd_sum = c_s + d_s;
  assign cd_dif = c_s - d_s;

  always_comb begin
    case (blk_phase)
      haar2d_pkg::BandLL: coef_sel = ab_sum + cd_sum;
      haar2d_pkg::BandH:  coef_sel = ab_dif + cd_dif;
      haar2d_pkg::BandV:  coef_sel = ab_sum - cd_sum;
      default:            coef_sel = ab_dif - cd_dif;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (coefs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_coef <= coef_sel;
      out_band <= blk_phase;
      out_row  <= blk_row;
      out_col  <= blk_col;
      out_last <= (blk_phase == haar2d_pkg::BandD);
    end
  end

  assign coefs.valid         = out_valid;
  assign coefs.coefficient   = out_coef;
  assign coefs.subband       = out_band;
  assign coefs.band_row      = out_row;
  assign coefs.band_col      = out_col;
  assign coefs.last_of_block = out_last;

endmodule

@@ hw/rtl/haar2d_regs.sv @@
// APB register block: frame width and height, clamped for the datapath.
module haar2d_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [haar2d_pkg::AddrW-1:0]      paddr,
  input  logic [haar2d_pkg::DataW-1:0]      pwdata,
  output logic [haar2d_pkg::DataW-1:0]      prdata,
  output logic                              pready,
  output haar2d_pkg::cfg_t                  cfg
);

  logic [haar2d_pkg::DimW-1:0] width;
  logic [haar2d_pkg::DimW-1:0] height;
  logic                        wr;
  haar2d_pkg::reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = haar2d_pkg::reg_idx_t'(paddr[2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= haar2d_pkg::WidthReset;
      height <= haar2d_pkg::HeightReset;
    end else if (wr) begin
      unique case (idx)
        haar2d_pkg::RegWidth:  width  <= pwdata[haar2d_pkg::DimW-1:0];
        haar2d_pkg::RegHeight: height <= pwdata[haar2d_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      haar2d_pkg::RegWidth:  prdata = haar2d_pkg::DataW'(width);
      haar2d_pkg::RegHeight: prdata = haar2d_pkg::DataW'(height);
      default:               prdata = '0;
    endcase
  end

  // Clamped geometry; any write restarts the frame
  assign cfg.width   = haar2d_pkg::clamp_dim(width, haar2d_pkg::DimW'(haar2d_pkg::MaxWidth));
  assign cfg.height  = haar2d_pkg::clamp_dim(height,
                                             haar2d_pkg::DimW'(haar2d_pkg::HeightLimit));
  assign cfg.restart = wr;

endmodule

@@ hw/rtl/haar2d_checker.sv @@
// Port-level checks on the coefficient stream of the Haar transform top level.
module haar2d_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [haar2d_pkg::CoefW-1:0] coefficient,
  input logic [haar2d_pkg::BandW-1:0]        subband,
  input logic [haar2d_pkg::PosW-1:0]         band_row,
  input logic [haar2d_pkg::PosW-1:0]         band_col,
  input logic                                last_of_block
);

  // A stalled transaction keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(subband)
      && $stable(band_row) && $stable(band_col) && $stable(last_of_block))
    else $error("coefficient payload changed while stalled");

  // LL taken: horizontal detail of the same block follows at once
  a_ll_then_h: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && subband == haar2d_pkg::BandLL
      |=> out_valid && subband == haar2d_pkg::BandH
        && band_row == $past(band_row) && band_col == $past(band_col))
    else $error("horizontal detail did not follow LL");

  // Vertical taken: the closing diagonal follows with the last flag
  a_v_then_d: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && subband == haar2d_pkg::BandV
      |=> out_valid && subband == haar2d_pkg::BandD && last_of_block
        && band_col == $past(band_col))
    else $error("diagonal did not close the block");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind haar_2d_one_level_transform_top haar2d_checker u_haar2d_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (coefs.valid),
  .out_ready     (coefs.ready),
  .coefficient   (coefs.coefficient),
  .subband       (coefs.subband),
  .band_row      (coefs.band_row),
  .band_col      (coefs.band_col),
  .last_of_block (coefs.last_of_block)
);
